>>> hdl/vdt_pkg.sv
// Package for the variable duty triangle LFO: widths, fixed-point constants,
// reset values and the command and status types between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package vdt_pkg;

    // Width of lengths and of the phase counter.
    localparam int LENGTH_BITS = 20;
    // Shortest remainder of a segment after a resync.
    localparam int MIN_RESYNC_LENGTH = 4;

    localparam int LEN_W   = LENGTH_BITS;
    localparam int FRAC_W  = 22;
    localparam int ACC_W   = 32;
    localparam int CALC_W  = 34;
    localparam int LEVEL_W = 8;
    localparam int PERIOD_W = 20;
    localparam int DUTY_W  = 9;
    localparam int CFG_W   = 20;
    localparam int ADDR_W  = 1;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam longint unsigned LEN_MAX   = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam longint unsigned DUTY_FULL = 256;
    localparam int unsigned     LEVEL_MAX = 255;

    // Q9.22 value of the top of the ramp.
    localparam logic signed [ACC_W-1:0] TOP_RAW = ACC_W'(LEVEL_MAX) << FRAC_W;

    // Register indexes of the configuration port.
    localparam logic [ADDR_W-1:0] REG_PERIOD = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_DUTY   = ADDR_W'(1);

    localparam longint unsigned RESET_PERIOD = 8000;
    localparam longint unsigned RESET_DUTY   = 128;
    localparam longint unsigned RESET_P =
        (RESET_PERIOD > LEN_MAX) ? LEN_MAX : RESET_PERIOD;
    localparam longint unsigned RESET_RISE = (RESET_P * RESET_DUTY) >> 8;
    localparam longint unsigned RESET_FALL = RESET_P - RESET_RISE;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic resync_len;   // derive rise and fall lengths from the registers
        logic resync_seg;   // re-length the current segment, restart the phase
        logic flip;         // change direction and load the new segment length
        logic div_start;    // start the slope division
        logic update;       // step the accumulator and register the level
    } vdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flip_needed;  // phase has reached the segment length
        logic div_done;     // slope division finished this cycle
    } vdt_status_t;

endpackage

>>> hdl/vdt_div.sv
// Bit-serial signed divider for the slope: one quotient bit per cycle,
// quotient truncated toward zero. Uses widths from vdt_pkg.
module vdt_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vdt_pkg::ACC_W-1:0]  dividend,
    input  logic        [vdt_pkg::LEN_W-1:0]  divisor,
    output logic                              done,
    output logic signed [vdt_pkg::ACC_W-1:0]  quotient
);
    import vdt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [ACC_W-1:0]     mag_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     den_reg;

    logic [LEN_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, mag_reg[ACC_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACC_W-1];
            mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? LEN_W'(trial - {1'b0, den_reg}) : trial[LEN_W-1:0];
            mag_reg <= {mag_reg[ACC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);

endmodule

>>> hdl/vdt_dp.sv
// Datapath of the variable duty triangle LFO: configuration registers,
// oscillator state, segment arithmetic and the output level register.
// Depends on vdt_pkg and instantiates vdt_div.
module vdt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vdt_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [vdt_pkg::CFG_W-1:0]           cfg_data,
    input  vdt_pkg::vdt_cmd_t                   cmd,
    output vdt_pkg::vdt_status_t                status,
    output logic [vdt_pkg::LEVEL_W-1:0]         level
);
    import vdt_pkg::*;

    logic [PERIOD_W-1:0]     period_reg;
    logic [DUTY_W-1:0]       duty_reg;
    logic                    falling_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] slope_reg;
    logic [LEN_W-1:0]        phase_reg;
    logic [LEN_W-1:0]        seg_reg;
    logic [LEN_W-1:0]        rise_reg;
    logic [LEN_W-1:0]        fall_reg;
    logic [LEVEL_W-1:0]      level_reg;

    logic [LEN_W-1:0]        p_clamped;
    logic [DUTY_W-1:0]       d_clamped;
    logic [LEN_W+DUTY_W-1:0] product;
    logic [LEN_W-1:0]        rise_next;
    logic [LEN_W-1:0]        fall_next;
    logic signed [CALC_W-1:0] remain_s;
    logic signed [CALC_W-1:0] remain_lim;
    logic [LEN_W-1:0]        seg_resync;
    logic [LEN_W-1:0]        seg_flip;
    logic signed [ACC_W-1:0] target;
    logic signed [ACC_W-1:0] div_dividend;
    logic signed [ACC_W-1:0] div_quot;
    logic                    div_done;
    logic signed [ACC_W-1:0] acc_next;
    logic [LEVEL_W-1:0]      level_next;
    logic [ACC_W-FRAC_W-2:0] whole;

    // Lengths from period and duty share.
    always_comb
    begin
        if (CALC_W'(period_reg) > CALC_W'(LEN_MAX))
            p_clamped = LEN_W'(LEN_MAX);
        else
            p_clamped = LEN_W'(CALC_W'(period_reg));
        if (CALC_W'(duty_reg) > CALC_W'(DUTY_FULL))
            d_clamped = DUTY_W'(DUTY_FULL);
        else
            d_clamped = duty_reg;
        product   = (LEN_W+DUTY_W)'(p_clamped) * (LEN_W+DUTY_W)'(d_clamped);
        rise_next = product[LEN_W+7:8];
        fall_next = p_clamped - rise_next;
    end

    // Remaining length of the current segment after a resync.
    always_comb
    begin
        remain_s = signed'(CALC_W'(falling_reg ? fall_reg : rise_reg))
                 - signed'(CALC_W'(phase_reg));
        remain_lim = remain_s;
        if (remain_lim < signed'(CALC_W'(MIN_RESYNC_LENGTH)))
            remain_lim = signed'(CALC_W'(MIN_RESYNC_LENGTH));
        if (remain_lim > signed'(CALC_W'(LEN_MAX)))
            remain_lim = signed'(CALC_W'(LEN_MAX));
        seg_resync = LEN_W'(remain_lim);
    end

    // Length of the next segment at a direction change; zero is taken as one.
    always_comb
    begin
        seg_flip = falling_reg ? rise_reg : fall_reg;
        if (seg_flip == '0)
            seg_flip = LEN_W'(1);
    end

    assign target       = falling_reg ? '0 : TOP_RAW;
    assign div_dividend = target - acc_reg;

    vdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (seg_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next level: floor of the accumulator, saturated at 255; negative reads as all ones.
    always_comb
    begin
        acc_next = acc_reg + slope_reg;
        whole    = acc_next[ACC_W-2:FRAC_W];
        if (acc_next[ACC_W-1])
            level_next = '1;
        else if ((ACC_W-FRAC_W-1)'(whole) > (ACC_W-FRAC_W-1)'(LEVEL_MAX))
            level_next = LEVEL_W'(LEVEL_MAX);
        else
            level_next = LEVEL_W'(whole);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_W'(RESET_PERIOD);
            duty_reg    <= DUTY_W'(RESET_DUTY);
            falling_reg <= 1'b0;
            acc_reg     <= '0;
            slope_reg   <= '0;
            phase_reg   <= '0;
            seg_reg     <= LEN_W'(RESET_RISE);
            rise_reg    <= LEN_W'(RESET_RISE);
            fall_reg    <= LEN_W'(RESET_FALL);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_DUTY:   duty_reg   <= cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.resync_len)
            begin
                rise_reg <= rise_next;
                fall_reg <= fall_next;
            end
            if (cmd.resync_seg)
            begin
                seg_reg   <= seg_resync;
                phase_reg <= '0;
            end
            if (cmd.flip)
            begin
                falling_reg <= ~falling_reg;
                seg_reg     <= seg_flip;
                phase_reg   <= '0;
            end
            if (div_done)
                slope_reg <= div_quot;
            if (cmd.update)
            begin
                acc_reg   <= acc_next;
                phase_reg <= phase_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            level_reg <= level_next;
    end

    assign status.flip_needed = phase_reg >= seg_reg;
    assign status.div_done    = div_done;
    assign level              = level_reg;

endmodule

>>> hdl/vdt_ctrl.sv
// Controller of the variable duty triangle LFO: sequences resync, direction
// change, slope division and the accumulator step, and owns both handshakes.
// Depends on vdt_pkg for the command and status types.
module vdt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   resync,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vdt_pkg::vdt_cmd_t      cmd,
    input  vdt_pkg::vdt_status_t   status
);
    import vdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RES_LEN,
        S_RES_SEG,
        S_CHECK,
        S_FLIP,
        S_DIV_START,
        S_DIV_WAIT,
        S_UPDATE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    assign cmd.resync_len = state_reg == S_RES_LEN;
    assign cmd.resync_seg = state_reg == S_RES_SEG;
    assign cmd.flip       = state_reg == S_FLIP;
    assign cmd.div_start  = state_reg == S_DIV_START;
    assign cmd.update     = (state_reg == S_UPDATE) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new level takes the output register the moment it is free.
            if (cmd.update)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= resync ? S_RES_LEN : S_CHECK;
                end
                S_RES_LEN:   state_reg <= S_RES_SEG;
                S_RES_SEG:   state_reg <= S_DIV_START;
                S_CHECK:     state_reg <= status.flip_needed ? S_FLIP : S_UPDATE;
                S_FLIP:      state_reg <= S_DIV_START;
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (status.div_done)
                        state_reg <= S_CHECK;
                end
                S_UPDATE:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A finished division always hands control back to the flip check.
    a_div_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && status.div_done) |=> state_reg == S_CHECK)
        else $error("division finished without returning to the check");

    // A direction change is only issued when the phase reached the length.
    a_flip_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flip |-> status.flip_needed)
        else $error("flip issued while the segment is still running");

    // An accumulator step always loads the result register and returns the controller to idle.
    a_update_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("accumulator step did not present a result");

    // Once a transaction is taken, no new one is accepted in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted back to back");

endmodule

>>> hdl/variable_duty_triangle_lfo.sv
// Top level of the variable duty triangle LFO: joins controller and datapath.
// Depends on vdt_pkg, vdt_ctrl and vdt_dp (which holds vdt_div).
//
// Each input transaction is one sample tick and yields one output transaction
// carrying an 8-bit level. The oscillator ramps a Q9.22 accumulator up toward
// 255 and down toward 0, with the rise and fall lengths set by the period and
// duty registers; the registers take effect only on a tick with resync set.
// A plain tick is accepted in the idle state, passes the check state and
// loads the result register in the update state, which waits until the output
// register is free. A tick that ends a segment, and every resync tick, first
// goes through the slope division, because the new slope comes from a
// bit-serial divider that produces one quotient bit per cycle over the 32-bit
// accumulator width and ends with a finishing pulse. A resync never ends a
// segment in the same tick. The result sits in an output register, so the next
// tick is accepted while it waits to be taken; the next result is held back
// only until that register is free. Configuration writes are registered and
// are meant to happen while the block is idle.
module variable_duty_triangle_lfo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vdt_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [vdt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          resync,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vdt_pkg::LEVEL_W-1:0]   level
);
    import vdt_pkg::*;

    vdt_cmd_t    cmd;
    vdt_status_t status;

    // The controller sequences each tick; it alone talks to the handshakes.
    vdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .resync    (resync),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the registers, oscillator state and the level output.
    vdt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .level    (level)
    );

endmodule
